// ===== rtl/core/servo_angle_slew_limiter_core_assert.svh =====
// Assertion macros used by the slew limiter checker
`ifndef SERVO_ANGLE_SLEW_LIMITER_CORE_ASSERT_SVH
`define SERVO_ANGLE_SLEW_LIMITER_CORE_ASSERT_SVH

// same-cycle implication, sampled on clk, quiet during reset
`define SASL_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SASL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/sasl_pkg.sv =====
// Types and constants for the servo angle slew limiter
package sasl_pkg;

    localparam logic [8:0]  ANGLE_IN_MAX = 9'd360;
    localparam logic [7:0]  ANGLE_MAX    = 8'd180;
    localparam logic [7:0]  ANGLE_HOME   = 8'd90;

    localparam logic [7:0]  RAMP_STEP_RST     = 8'd3;
    localparam logic [15:0] RAMP_INTERVAL_RST = 16'd8;
    localparam logic [11:0] PULSE_MIN_RST     = 12'd1000;
    localparam logic [11:0] PULSE_MAX_RST     = 12'd2000;

    // x/180 == (x>>2)/45; ceil(2^24/45) is exact for x>>2 below 2^18
    localparam int          RECIP_SHIFT = 24;
    localparam logic [18:0] RECIP_45    = 19'd372828;

    typedef enum logic [1:0] {
        CFG_RAMP_STEP     = 2'd0,
        CFG_RAMP_INTERVAL = 2'd1,
        CFG_PULSE_MIN     = 2'd2,
        CFG_PULSE_MAX     = 2'd3
    } cfg_idx_t;

    typedef enum logic {
        OP_TICK       = 1'b0,
        OP_SET_TARGET = 1'b1
    } op_t;

    typedef struct packed {
        logic               operation;
        logic signed [15:0] raw_angle;
    } cmd_t;

    typedef struct packed {
        logic [7:0]  target_angle;
        logic [7:0]  current_angle;
        logic [11:0] target_pulse_us;
        logic [11:0] drive_pulse_us;
        logic        drive_updated;
    } res_t;

endpackage

// ===== rtl/core/servo_angle_slew_limiter_core.sv =====
// Servo angle slew limiter: target clamp, ramp stepping and pulse width mapping
//
// Command channel (cmd_valid / cmd_stall / cmd): each item is either a one
// millisecond tick or a set-target command carrying a signed raw angle.
// Result channel (res_valid / res_stall / res): exactly one result item per
// command item, in order, carrying goal and current angle, both pulse widths
// and a flag set when a tick moved the current angle.
// Configuration channel (cfg_valid / cfg_ready / cfg_index / cfg_data):
// cfg_ready is always high; write only while no item is in flight.
// Pipeline: three register stages (angle update, angle x pulse span product,
// reciprocal divide by 180 plus offset); an accepted item passes s1, s2 and
// the result register in turn. Throughput: one item per cycle unless stalled;
// the two multiplier stages are pipelined.
// Reset: angles return to 90 degrees, the tick counter to 0, registers to
// step 3, interval 8, pulses 1000..2000 us; pipeline and result empty.
// Stall: a stalled result holds; s1 and s2 keep filling, and cmd_stall rises
// only once every stage holds an item.
module servo_angle_slew_limiter_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_valid,
    output logic                 cmd_stall,
    input  sasl_pkg::cmd_t       cmd,
    output logic                 res_valid,
    input  logic                 res_stall,
    output sasl_pkg::res_t       res,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  sasl_pkg::cfg_idx_t   cfg_index,
    input  logic [15:0]          cfg_data
);

    // configuration
    logic [7:0]  ramp_step_reg;
    logic [15:0] ramp_interval_reg;
    logic [11:0] pulse_min_reg;
    logic [11:0] pulse_max_reg;

    // block state
    logic [7:0]  angle_now_reg,  angle_now_next;
    logic [7:0]  angle_goal_reg, angle_goal_next;
    logic [15:0] ms_cnt_reg,     ms_cnt_next;
    logic        moved_next;

    // pipeline
    logic        s1_valid_reg, s2_valid_reg, res_valid_reg;
    logic [7:0]  s1_goal_reg, s1_now_reg, s2_goal_reg, s2_now_reg;
    logic        s1_moved_reg, s2_moved_reg;
    logic [17:0] s2_goal_x_reg, s2_now_x_reg;
    sasl_pkg::res_t res_reg, res_next;

    logic        out_free, s2_free, s1_free, accept;

    logic [12:0] span;
    logic        span_neg;
    logic [11:0] span_mag;
    logic [19:0] goal_prod, now_prod;
    logic [36:0] goal_q_prod, now_q_prod;
    logic [11:0] goal_q, now_q;

    logic [8:0]  clamp_ang;
    logic [9:0]  clamp_inc;
    logic [15:0] cnt_inc;
    logic [7:0]  gap;

    assign cfg_ready = 1'b1;

    // handshake chain
    assign out_free  = !res_valid_reg || !res_stall;
    assign s2_free   = !s2_valid_reg || out_free;
    assign s1_free   = !s1_valid_reg || s2_free;
    assign cmd_stall = !s1_free;
    assign accept    = cmd_valid && s1_free;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ramp_step_reg     <= sasl_pkg::RAMP_STEP_RST;
            ramp_interval_reg <= sasl_pkg::RAMP_INTERVAL_RST;
            pulse_min_reg     <= sasl_pkg::PULSE_MIN_RST;
            pulse_max_reg     <= sasl_pkg::PULSE_MAX_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                sasl_pkg::CFG_RAMP_STEP:     ramp_step_reg     <= cfg_data[7:0];
                sasl_pkg::CFG_RAMP_INTERVAL: ramp_interval_reg <= cfg_data;
                sasl_pkg::CFG_PULSE_MIN:     pulse_min_reg     <= cfg_data[11:0];
                sasl_pkg::CFG_PULSE_MAX:     pulse_max_reg     <= cfg_data[11:0];
                default: ;
            endcase
        end
    end

    // angle update for the accepted item
    always_comb
    begin
        angle_now_next  = angle_now_reg;
        angle_goal_next = angle_goal_reg;
        ms_cnt_next     = ms_cnt_reg;
        moved_next      = 1'b0;
        cnt_inc         = ms_cnt_reg + 16'd1;
        gap             = 8'd0;

        if (cmd.raw_angle[15])
            clamp_ang = 9'd0;
        else if (cmd.raw_angle[14:0] > {6'd0, sasl_pkg::ANGLE_IN_MAX})
            clamp_ang = sasl_pkg::ANGLE_IN_MAX;
        else
            clamp_ang = cmd.raw_angle[8:0];
        clamp_inc = {1'b0, clamp_ang} + 10'd1;

        if (cmd.operation == sasl_pkg::OP_SET_TARGET)
        begin
            if (clamp_ang > {1'b0, sasl_pkg::ANGLE_MAX})
                angle_goal_next = clamp_inc[8:1];
            else
                angle_goal_next = clamp_ang[7:0];
        end
        else if (cnt_inc >= ramp_interval_reg)
        begin
            ms_cnt_next = 16'd0;
            if (angle_now_reg != angle_goal_reg && ramp_step_reg != 8'd0)
            begin
                moved_next = 1'b1;
                if (angle_goal_reg > angle_now_reg)
                begin
                    gap = angle_goal_reg - angle_now_reg;
                    angle_now_next = (gap <= ramp_step_reg) ? angle_goal_reg
                                   : angle_now_reg + ramp_step_reg;
                end
                else
                begin
                    gap = angle_now_reg - angle_goal_reg;
                    angle_now_next = (gap <= ramp_step_reg) ? angle_goal_reg
                                   : angle_now_reg - ramp_step_reg;
                end
            end
        end
        else
        begin
            ms_cnt_next = cnt_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angle_now_reg  <= sasl_pkg::ANGLE_HOME;
            angle_goal_reg <= sasl_pkg::ANGLE_HOME;
            ms_cnt_reg     <= 16'd0;
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                angle_now_reg  <= angle_now_next;
                angle_goal_reg <= angle_goal_next;
                ms_cnt_reg     <= ms_cnt_next;
            end
            if (s1_free)
                s1_valid_reg <= accept;
            if (s2_free)
                s2_valid_reg <= s1_valid_reg;
            if (out_free)
                res_valid_reg <= s2_valid_reg;
        end
    end

    // pulse span as sign and magnitude, so products stay unsigned
    assign span     = {1'b0, pulse_max_reg} - {1'b0, pulse_min_reg};
    assign span_neg = span[12];
    assign span_mag = span_neg ? 12'(-span) : span[11:0];

    assign goal_prod = s1_goal_reg * span_mag;
    assign now_prod  = s1_now_reg  * span_mag;

    assign goal_q_prod = s2_goal_x_reg * sasl_pkg::RECIP_45;
    assign now_q_prod  = s2_now_x_reg  * sasl_pkg::RECIP_45;
    assign goal_q      = goal_q_prod[sasl_pkg::RECIP_SHIFT +: 12];
    assign now_q       = now_q_prod[sasl_pkg::RECIP_SHIFT +: 12];

    always_comb
    begin
        res_next.target_angle    = s2_goal_reg;
        res_next.current_angle   = s2_now_reg;
        res_next.drive_updated   = s2_moved_reg;
        res_next.target_pulse_us = span_neg ? pulse_min_reg - goal_q
                                            : pulse_min_reg + goal_q;
        res_next.drive_pulse_us  = span_neg ? pulse_min_reg - now_q
                                            : pulse_min_reg + now_q;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_goal_reg  <= angle_goal_next;
            s1_now_reg   <= angle_now_next;
            s1_moved_reg <= moved_next;
        end
        if (s2_free && s1_valid_reg)
        begin
            s2_goal_reg   <= s1_goal_reg;
            s2_now_reg    <= s1_now_reg;
            s2_moved_reg  <= s1_moved_reg;
            s2_goal_x_reg <= goal_prod[19:2];
            s2_now_x_reg  <= now_prod[19:2];
        end
        if (out_free && s2_valid_reg)
            res_reg <= res_next;
    end

endmodule

// ===== rtl/core/sasl_checker.sv =====
// Port-level checker for the slew limiter, bound to the core module
`include "servo_angle_slew_limiter_core_assert.svh"

module sasl_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           cmd_valid,
    input logic           cmd_stall,
    input sasl_pkg::cmd_t cmd,
    input logic           res_valid,
    input logic           res_stall,
    input sasl_pkg::res_t res
);

    logic res_wait;
    logic cmd_wait;
    logic angles_ok;

    assign res_wait  = res_valid && res_stall;
    assign cmd_wait  = cmd_valid && cmd_stall;
    assign angles_ok = res.target_angle <= sasl_pkg::ANGLE_MAX
                    && res.current_angle <= sasl_pkg::ANGLE_MAX;

    `SASL_ASSERT_NEXT(a_res_hold, res_wait, res_valid && $stable(res), "stalled result changed")

    `SASL_ASSERT_NOW(a_angle_range, res_valid, angles_ok, "result angle above 180 degrees")

    `SASL_ASSERT_NOW(a_stall_backup, cmd_stall, res_wait, "command stalled with result free")

    `SASL_ASSERT_NEXT(a_cmd_hold, cmd_wait, cmd_valid && $stable(cmd), "stalled command changed")

endmodule

bind servo_angle_slew_limiter_core sasl_checker u_sasl_checker (.*);

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the servo angle slew limiter core
module tb_top;

    localparam int HOLD_CYCLES   = 300;
    localparam int STALL_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 8;
    localparam int IDLE_PERCENT  = 17;
    localparam int AIM_PERCENT   = 12;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cmd_valid = 1'b0;
    logic               cmd_stall;
    sasl_pkg::cmd_t     cmd = '0;
    logic               res_valid;
    logic               res_stall;
    sasl_pkg::res_t     res;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    sasl_pkg::cfg_idx_t cfg_index = sasl_pkg::CFG_RAMP_STEP;
    logic [15:0]        cfg_data = '0;

    // shadow copy of the block's registers and angle state
    logic [7:0]  step_deg    = sasl_pkg::RAMP_STEP_RST;
    logic [15:0] interval_ms = sasl_pkg::RAMP_INTERVAL_RST;
    logic [11:0] pulse_lo    = sasl_pkg::PULSE_MIN_RST;
    logic [11:0] pulse_hi    = sasl_pkg::PULSE_MAX_RST;
    int          angle_now   = int'(sasl_pkg::ANGLE_HOME);
    int          angle_goal  = int'(sasl_pkg::ANGLE_HOME);
    logic [15:0] ms_count    = '0;

    sasl_pkg::res_t due_reports[$];
    int          mismatches = 0;
    bit          idle_on = 1'b1;
    int          hold_requests = 0;
    int          quiet_cycles = 0;

    servo_angle_slew_limiter_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic logic [11:0] angle_pulse(input int angle);
        int lo;
        int span;
        int width;
        lo    = int'(pulse_lo);
        span  = int'(pulse_hi) - lo;
        // signed division, truncates toward zero as the block does
        width = lo + (angle * span) / int'(sasl_pkg::ANGLE_MAX);
        return width[11:0];
    endfunction

    task automatic ramp_servo(input sasl_pkg::cmd_t item);
        sasl_pkg::res_t report;
        int   want;
        int   next;
        report.drive_updated = 1'b0;
        if (item.operation == sasl_pkg::OP_SET_TARGET)
        begin
            want = $signed(item.raw_angle);
            if (want < 0) want = 0;
            if (want > int'(sasl_pkg::ANGLE_IN_MAX)) want = int'(sasl_pkg::ANGLE_IN_MAX);
            if (want > int'(sasl_pkg::ANGLE_MAX)) want = (want + 1) / 2;
            angle_goal = want;
        end
        else
        begin
            ms_count = ms_count + 16'd1;
            if (ms_count >= interval_ms)
            begin
                ms_count = '0;
                if (angle_now != angle_goal && step_deg != 8'd0)
                begin
                    if (angle_goal > angle_now)
                    begin
                        next = angle_now + int'(step_deg);
                        if (next > angle_goal) next = angle_goal;
                    end
                    else
                    begin
                        next = angle_now - int'(step_deg);
                        if (next < angle_goal) next = angle_goal;
                    end
                    if (next != angle_now) report.drive_updated = 1'b1;
                    angle_now = next;
                end
            end
        end
        report.target_angle    = angle_goal[7:0];
        report.current_angle   = angle_now[7:0];
        report.target_pulse_us = angle_pulse(angle_goal);
        report.drive_pulse_us  = angle_pulse(angle_now);
        due_reports.push_back(report);
    endtask

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // result checking and the no-progress watchdog
    always @(posedge clk)
    begin
        sasl_pkg::res_t want_rep;
        if (rst_n)
        begin
            if (res_valid && !res_stall)
            begin
                if (due_reports.size() == 0)
                begin
                    $display("%0t: unexpected result expected none actual %h", $time, res);
                    mismatches++;
                end
                else
                begin
                    want_rep = due_reports.pop_front();
                    check_field("target_angle", want_rep.target_angle, res.target_angle);
                    check_field("current_angle", want_rep.current_angle, res.current_angle);
                    check_field("target_pulse_us", want_rep.target_pulse_us,
                                res.target_pulse_us);
                    check_field("drive_pulse_us", want_rep.drive_pulse_us,
                                res.drive_pulse_us);
                    check_field("drive_updated", want_rep.drive_updated, res.drive_updated);
                end
            end
            if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
                $display("servo_angle_slew_limiter_core verification failed");
                $finish;
            end
        end
    end

    // result side: random stalls, plus long hold-offs on request
    initial
    begin
        int hold_left;
        int holds_done;
        hold_left  = 0;
        holds_done = 0;
        res_stall  = 1'b0;
        forever
        begin
            @(posedge clk);
            if (holds_done != hold_requests)
            begin
                holds_done = hold_requests;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                res_stall <= 1'b1;
                hold_left--;
            end
            else
                res_stall <= idle_on && ($urandom_range(99) < IDLE_PERCENT);
        end
    end

    // valid is left high after an item so back-to-back items need no toggle
    task automatic send_cmd(input sasl_pkg::op_t op, input logic [15:0] raw);
        sasl_pkg::cmd_t item;
        item.operation = op;
        item.raw_angle = raw;
        while (idle_on && $urandom_range(99) < IDLE_PERCENT)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd       <= item;
        @(posedge clk);
        while (cmd_stall) @(posedge clk);
        ramp_servo(item);
    endtask

    task automatic tick(input int count);
        repeat (count) send_cmd(sasl_pkg::OP_TICK, 16'($urandom));
    endtask

    task automatic aim(input logic [15:0] raw);
        send_cmd(sasl_pkg::OP_SET_TARGET, raw);
    endtask

    task automatic send_random_item();
        logic [15:0] raw;
        case ($urandom_range(9))
            0: raw = 16'($urandom);
            1: raw = 16'($urandom_range(361, 32767));
            2: raw = 16'(-int'($urandom_range(1, 32768)));
            default: raw = 16'($urandom_range(0, 360));
        endcase
        if ($urandom_range(99) < AIM_PERCENT)
            send_cmd(sasl_pkg::OP_SET_TARGET, raw);
        else
            send_cmd(sasl_pkg::OP_TICK, raw);
    endtask

    task automatic drain_results();
        cmd_valid <= 1'b0;
        while (due_reports.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input sasl_pkg::cfg_idx_t idx, input logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            sasl_pkg::CFG_RAMP_STEP:     step_deg    = value[7:0];
            sasl_pkg::CFG_RAMP_INTERVAL: interval_ms = value;
            sasl_pkg::CFG_PULSE_MIN:     pulse_lo    = value[11:0];
            sasl_pkg::CFG_PULSE_MAX:     pulse_hi    = value[11:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic set_ramp(input logic [7:0] step, input logic [15:0] interval,
                            input logic [11:0] lo, input logic [11:0] hi);
        drain_results();
        write_reg(sasl_pkg::CFG_RAMP_STEP, {8'd0, step});
        write_reg(sasl_pkg::CFG_RAMP_INTERVAL, interval);
        write_reg(sasl_pkg::CFG_PULSE_MIN, {4'd0, lo});
        write_reg(sasl_pkg::CFG_PULSE_MAX, {4'd0, hi});
    endtask

    // clamp and halving of the target at reset settings
    task automatic test_target_clamp();
        aim(16'h8000);
        aim(16'hFFFF);
        aim(16'd0);
        aim(16'd1);
        aim(16'd180);
        aim(16'd181);
        aim(16'd182);
        aim(16'd359);
        aim(16'd360);
        aim(16'd361);
        aim(16'h7FFF);
        aim(16'h5555);
        aim(16'hAAAA);
        tick(9);
    endtask

    task automatic test_ramp_corners();
        // zero interval steps every tick; oversized step lands on the goal
        set_ramp(8'd255, 16'd0, sasl_pkg::PULSE_MIN_RST, sasl_pkg::PULSE_MAX_RST);
        aim(16'd180);
        tick(2);
        aim(16'd0);
        tick(2);
        // zero step never moves
        set_ramp(8'd0, 16'd1, sasl_pkg::PULSE_MIN_RST, sasl_pkg::PULSE_MAX_RST);
        aim(16'd90);
        tick(3);
        // interval dropped under the running count
        set_ramp(8'd7, 16'd10, sasl_pkg::PULSE_MIN_RST, sasl_pkg::PULSE_MAX_RST);
        tick(6);
        drain_results();
        write_reg(sasl_pkg::CFG_RAMP_INTERVAL, 16'd2);
        tick(2);
    endtask

    task automatic test_pulse_limits();
        set_ramp(8'd1, 16'd1, 12'd2500, 12'd500);
        aim(16'd0);
        aim(16'd180);
        tick(3);
        set_ramp(8'd90, 16'd1, 12'd0, 12'd4095);
        aim(16'd360);
        tick(2);
        set_ramp(8'd1, 16'd1, 12'd4095, 12'd4095);
        aim(16'd45);
        tick(1);
        set_ramp(8'd45, 16'd1, 12'd4095, 12'd0);
        aim(16'd1);
        tick(2);
    endtask

    task automatic test_back_pressure();
        set_ramp(8'd2, 16'd1, 12'd1000, 12'd2000);
        hold_requests++;
        repeat (60) send_random_item();
        drain_results();
    endtask

    task automatic test_sender_pause();
        repeat (4)
        begin
            repeat (15) send_random_item();
            drain_results();
        end
    endtask

    task automatic test_random_phases();
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0: set_ramp(8'd1, 16'd1, 12'd500, 12'd2500);
                1: set_ramp(8'd180, 16'd0, 12'd2500, 12'd500);
                2: set_ramp(8'd255, 16'd65535, 12'd0, 12'd4095);
                3: set_ramp(8'd0, 16'd2, 12'd700, 12'd2300);
                default: set_ramp(8'($urandom_range(1, 20)), 16'($urandom_range(0, 5)),
                                  12'($urandom), 12'($urandom));
            endcase
            // one phase runs flat out on both sides
            idle_on = (ph != 5);
            repeat (135) send_random_item();
        end
        idle_on = 1'b1;
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_target_clamp();
        test_ramp_corners();
        test_pulse_limits();
        test_back_pressure();
        test_sender_pause();
        test_random_phases();
        drain_results();
        if (mismatches == 0)
            $display("servo_angle_slew_limiter_core verification clean");
        else
            $display("servo_angle_slew_limiter_core verification failed");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/sasl_pkg.sv
rtl/core/servo_angle_slew_limiter_core.sv
rtl/core/sasl_checker.sv
sim/tb_top.sv
